// ===== rtl/atws_pkg.sv =====
`timescale 1ns / 1ps

package atws_pkg;

  // Default number of alarm slots
  localparam int ALARM_SLOTS_DEF = 16;

  // Most results that one tick may give
  localparam int RESULT_LIMIT = 16;
  localparam int FIRE_W       = $clog2(RESULT_LIMIT);

  // Slot record in RAM: trigger time over alarm id
  localparam int TRIG_W = 64;
  localparam int IDENT_W = 32;
  localparam int SLOT_W = TRIG_W + IDENT_W;

  typedef enum logic [1:0] {
    KIND_SET    = 2'd0,
    KIND_CANCEL = 2'd1,
    KIND_TICK   = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    STAT_SET_OK    = 3'd0,
    STAT_FULL      = 3'd1,
    STAT_CANCELLED = 3'd2,
    STAT_NOT_FOUND = 3'd3,
    STAT_FIRED     = 3'd4,
    STAT_NONE      = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESOLVE
  } state_t;

  typedef struct packed {
    kind_t               kind;
    logic [TRIG_W-1:0]   due_time;
    logic [IDENT_W-1:0]  cancel_tag;
    logic [TRIG_W-1:0]   now;
  } in_t;

  typedef struct packed {
    status_t             status;
    logic [IDENT_W-1:0]  id;
    logic                last;
  } out_t;

endpackage

// ===== rtl/atws_ram.sv =====
`timescale 1ns / 1ps

module atws_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, register the read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/alarm_table_with_expiry_scan.sv =====
`timescale 1ns / 1ps

// Channel   Ports                   Handshake
// --------  ----------------------  ------------------------------------------
// item      item (in_t)             beat taken when start is high, busy is low
// result    result (out_t)          beat shown for one cycle with result_valid
//
// Set and cancel scan all slots once through the slot RAM read port; a tick
// scans them in one pass per result, up to RESULT_LIMIT passes. Each result
// is registered from the resolve step that closes its pass. Kind 3 is taken
// and dropped.
// Reset clears the active bits and the id counter; no clearing pass.
// The receiver cannot stall; busy holds off new items during a scan.

module alarm_table_with_expiry_scan
  import atws_pkg::*;
#(
  parameter int ALARM_SLOTS = ALARM_SLOTS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  in_t  item,
  output logic result_valid,
  output out_t result
);

  localparam int IDX_W = (ALARM_SLOTS > 1) ? $clog2(ALARM_SLOTS) : 1;
  localparam int CNT_W = $clog2(ALARM_SLOTS + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ALARM_SLOTS - 1);
  localparam logic [CNT_W-1:0] SCAN_END = CNT_W'(ALARM_SLOTS);
  localparam logic [FIRE_W-1:0] FIRE_LAST = FIRE_W'(RESULT_LIMIT - 1);

  state_t state, state_next;

  in_t                cur;
  logic [ALARM_SLOTS-1:0] slot_active;
  logic [IDENT_W-1:0] next_ident;

  logic [CNT_W-1:0]   scan_cnt;
  logic               rd_en;
  logic               eval_valid;
  logic [IDX_W-1:0]   eval_idx;

  logic               found;
  logic               multi;
  logic [IDX_W-1:0]   best_idx;
  logic [IDENT_W-1:0] best_age;
  logic [IDENT_W-1:0] best_ident;
  logic [FIRE_W-1:0]  fire_cnt;

  logic               ram_we;
  logic [SLOT_W-1:0]  ram_wdata;
  logic [SLOT_W-1:0]  ram_rdata;
  logic [TRIG_W-1:0]  rd_trig;
  logic [IDENT_W-1:0] rd_ident;

  logic               active_e;
  logic               flag;
  logic [IDENT_W-1:0] age;

  logic               rescan;
  logic               commit_set;
  logic               free_slot;
  logic               fire;
  logic               res_valid_next;
  out_t               res_next;

  // Slot records: trigger time and id
  atws_ram #(
    .WIDTH(SLOT_W),
    .DEPTH(ALARM_SLOTS)
  ) u_slot_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(best_idx),
    .wdata(ram_wdata),
    .raddr(scan_cnt[IDX_W-1:0]),
    .rdata(ram_rdata)
  );

  assign busy      = (state != ST_IDLE);
  assign rd_en     = (state == ST_SCAN) && (scan_cnt != SCAN_END);
  assign ram_wdata = {cur.due_time, next_ident};
  assign rd_trig   = ram_rdata[SLOT_W-1:IDENT_W];
  assign rd_ident  = ram_rdata[IDENT_W-1:0];

  // Judge the slot whose record just came out of the RAM
  always_comb begin
    active_e = slot_active[eval_idx];
    age      = next_ident - IDENT_W'(1) - rd_ident;
    case (cur.kind)
      KIND_SET:    flag = !active_e;
      KIND_CANCEL: flag = active_e && (rd_ident == cur.cancel_tag);
      KIND_TICK:   flag = active_e && (rd_trig <= cur.now);
      default:     flag = 1'b0;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and per-pass decisions
  always_comb begin
    state_next     = state;
    ram_we         = 1'b0;
    rescan         = 1'b0;
    commit_set     = 1'b0;
    free_slot      = 1'b0;
    fire           = 1'b0;
    res_valid_next = 1'b0;
    res_next       = '{status: STAT_NONE, id: '0, last: 1'b1};
    case (state)
      ST_IDLE: begin
        if (start) begin
          case (item.kind)
            KIND_SET, KIND_CANCEL, KIND_TICK: state_next = ST_SCAN;
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_SCAN: begin
        if (eval_valid && (eval_idx == LAST_IDX)) begin
          state_next = ST_RESOLVE;
        end
      end
      ST_RESOLVE: begin
        res_valid_next = 1'b1;
        state_next     = ST_IDLE;
        case (cur.kind)
          KIND_SET: begin
            if (found) begin
              ram_we     = 1'b1;
              commit_set = 1'b1;
              res_next   = '{status: STAT_SET_OK, id: next_ident, last: 1'b1};
            end else begin
              res_next   = '{status: STAT_FULL, id: '0, last: 1'b1};
            end
          end
          KIND_CANCEL: begin
            if (found) begin
              free_slot = 1'b1;
              res_next  = '{status: STAT_CANCELLED, id: cur.cancel_tag, last: 1'b1};
            end else begin
              res_next  = '{status: STAT_NOT_FOUND, id: '0, last: 1'b1};
            end
          end
          KIND_TICK: begin
            if (found) begin
              free_slot     = 1'b1;
              fire          = 1'b1;
              res_next      = '{status: STAT_FIRED, id: best_ident, last: 1'b1};
              // Another due alarm remains and the result limit is not hit
              if (multi && (fire_cnt != FIRE_LAST)) begin
                res_next.last = 1'b0;
                rescan        = 1'b1;
                state_next    = ST_SCAN;
              end
            end else begin
              res_next = '{status: STAT_NONE, id: '0, last: 1'b1};
            end
          end
          default: state_next = ST_IDLE;
        endcase
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control state: active bits, id counter, scan pipeline, result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_active  <= '0;
      next_ident   <= '0;
      eval_valid   <= 1'b0;
      result_valid <= 1'b0;
      scan_cnt     <= '0;
      found        <= 1'b0;
      multi        <= 1'b0;
      fire_cnt     <= '0;
    end else begin
      eval_valid   <= rd_en;
      result_valid <= res_valid_next;
      if (rd_en) begin
        scan_cnt <= scan_cnt + CNT_W'(1);
      end
      // Open a new pass
      if (((state == ST_IDLE) && start) || rescan) begin
        scan_cnt <= '0;
        found    <= 1'b0;
        multi    <= 1'b0;
      end
      if ((state == ST_IDLE) && start) begin
        fire_cnt <= '0;
      end
      // Track the pick of this pass
      if (eval_valid && flag) begin
        if (cur.kind == KIND_SET) begin
          found <= 1'b1;
        end else begin
          found <= 1'b1;
          if (found) begin
            multi <= 1'b1;
          end
        end
      end
      if (fire) begin
        fire_cnt <= fire_cnt + FIRE_W'(1);
      end
      if (commit_set) begin
        slot_active[best_idx] <= 1'b1;
        next_ident            <= next_ident + IDENT_W'(1);
      end
      if (free_slot) begin
        slot_active[best_idx] <= 1'b0;
      end
    end
  end

  // Payload: latched item, pick of the pass, result beat
  always_ff @(posedge clk) begin
    eval_idx <= scan_cnt[IDX_W-1:0];
    result   <= res_next;
    if ((state == ST_IDLE) && start) begin
      cur <= item;
    end
    if (eval_valid && flag) begin
      if (cur.kind == KIND_SET) begin
        // Lowest free slot wins
        if (!found) begin
          best_idx <= eval_idx;
        end
      end else if (!found || (age <= best_age)) begin
        // Newest wins, higher slot on equal age
        best_idx   <= eval_idx;
        best_age   <= age;
        best_ident <= rd_ident;
      end
    end
  end

endmodule
